// ===== hw/rtl/rbia_pkg.sv =====
// Shared types and codes of the ring buffer interval allocator.
`timescale 1ns / 1ps
package rbia_pkg;

	localparam int PTR_BITS = 25;
	localparam int OFS_IN_BITS = 24;
	localparam int CNT_OUT_BITS = 5;

	typedef enum logic [0:0] {
		REQ_ALLOC   = 1'b0,
		REQ_RELEASE = 1'b1
	} req_type_t;

	typedef enum logic [2:0] {
		ST_GRANTED  = 3'd0,
		ST_NO_ROOM  = 3'd1,
		ST_TOO_BIG  = 3'd2,
		ST_FULL     = 3'd3,
		ST_RELEASED = 3'd4,
		ST_UNKNOWN  = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DECIDE
	} fsm_t;

	localparam logic [1:0] REG_TOTAL_SIZE = 2'd0;
	localparam logic [24:0] TOTAL_SIZE_RESET = 25'd65536;

endpackage

// ===== hw/rtl/ring_buffer_interval_allocator_core.sv =====
// Top level of the ring buffer interval allocator.
// A new request is accepted only in idle, after the result of the previous one has been
// placed in the output register. The table scan reads one start entry per cycle from the
// start memory.
// Reset: arst_n clears pointers, valid bits, count and handshakes; total_size = 65536.
// The start memory needs no clearing pass: entries are read only behind valid bits.
`timescale 1ns / 1ps
module ring_buffer_interval_allocator_core
	import rbia_pkg::*;
#(
	parameter int MAX_OUTSTANDING = 16,
	parameter int OFFSET_BITS = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [55:0] s_axis_tdata,  // size[24:0], offset[48:25], zero fill
	input  logic        s_axis_tuser,  // req_type
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // granted_offset[23:0], busy_count[28:24], zero fill
	output logic [2:0]  m_axis_tuser,  // status
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int AW = (MAX_OUTSTANDING > 1) ? $clog2(MAX_OUTSTANDING) : 1;
	localparam int CNTW = $clog2(MAX_OUTSTANDING + 1);
	localparam int SW = OFFSET_BITS;
	localparam int CW = (OFFSET_BITS > PTR_BITS) ? OFFSET_BITS : PTR_BITS;

	fsm_t state_q, state_d;

	logic [PTR_BITS-1:0] total_q, ap_q, fe_q;
	logic [MAX_OUTSTANDING-1:0] valid_q;
	logic [CNTW-1:0] cnt_q;

	logic                req_q;
	logic [PTR_BITS-1:0] size_q;
	logic [SW-1:0]       rel_q;

	logic [AW-1:0] idx_q, idx_s1;
	logic          issue_q, vld_s1;

	logic [SW-1:0] lowest_q, next_q;
	logic          next_found_q, hit_ap_q, hit_zero_q, match_q, free_found_q;
	logic [AW-1:0] match_idx_q, free_idx_q;

	logic          out_valid_q;
	logic [2:0]    out_status_q;
	logic [23:0]   out_ofs_q;
	logic [CNTW-1:0] out_cnt_q;

	logic [SW-1:0] rd_data;
	logic          rd_en, ram_we, accept, decide_go, out_free;
	logic [SW-1:0] start_ap;
	logic [SW-1:0] in_ofs;

	assign pready = 1'b1;
	assign prdata = 32'(total_q);
	assign s_axis_tready = (state_q == S_IDLE);
	assign accept = s_axis_tvalid && s_axis_tready;
	assign out_free = !out_valid_q || m_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser = out_status_q;
	assign m_axis_tdata = {3'b000, CNT_OUT_BITS'(out_cnt_q), out_ofs_q};

	assign start_ap = SW'(CW'(ap_q));
	assign in_ofs = SW'(CW'(s_axis_tdata[48:25]));

	// Allocation decision
	logic [PTR_BITS-1:0] room1, room2, ap2, fe2, low25;
	logic wrap, fit, dup, empty, full;
	assign empty = (cnt_q == '0);
	assign full = (cnt_q == CNTW'(MAX_OUTSTANDING));
	assign low25 = PTR_BITS'(CW'(lowest_q));
	assign room1 = (fe_q >= ap_q) ? fe_q - ap_q : '0;
	assign wrap = !empty && (room1 < size_q) && (lowest_q != '0) && (fe_q == total_q);
	assign ap2 = (empty || wrap) ? '0 : ap_q;
	assign fe2 = empty ? total_q : (wrap ? low25 : fe_q);
	assign room2 = (fe2 >= ap2) ? fe2 - ap2 : '0;
	assign fit = (room2 >= size_q);
	assign dup = !empty && (wrap ? hit_zero_q : hit_ap_q);

	logic [SW-1:0] grant_start;
	assign grant_start = SW'(CW'(ap2));

	always_comb begin
		state_d = state_q;
		rd_en = 1'b0;
		ram_we = 1'b0;
		decide_go = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (accept) state_d = S_SCAN;
			end
			S_SCAN: begin
				rd_en = issue_q;
				if (vld_s1 && idx_s1 == AW'(MAX_OUTSTANDING - 1)) state_d = S_DECIDE;
			end
			S_DECIDE: begin
				if (out_free) begin
					decide_go = 1'b1;
					state_d = S_IDLE;
					ram_we = (req_q == REQ_ALLOC) && size_q != '0 && !full && fit && !dup;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	rbia_ram #(.WIDTH(SW), .DEPTH(MAX_OUTSTANDING)) u_starts (
		.clk   (clk),
		.we    (ram_we),
		.waddr (free_idx_q),
		.wdata (grant_start),
		.re    (rd_en),
		.raddr (idx_q),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= TOTAL_SIZE_RESET;
			ap_q <= '0;
			fe_q <= '0;
			valid_q <= '0;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
			issue_q <= 1'b0;
			vld_s1 <= 1'b0;
		end else begin
			if (psel && penable && pwrite && paddr == REG_TOTAL_SIZE) begin
				total_q <= pwdata[PTR_BITS-1:0];
			end
			if (decide_go) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end

			vld_s1 <= rd_en;
			if (accept) begin
				issue_q <= 1'b1;
			end else if (rd_en && idx_q == AW'(MAX_OUTSTANDING - 1)) begin
				issue_q <= 1'b0;
			end

			if (decide_go) begin
				if (req_q == REQ_ALLOC) begin
					if (size_q != '0 && !full) begin
						ap_q <= fit ? ap2 + size_q : ap2;
						fe_q <= fe2;
						if (fit && !dup) begin
							valid_q[free_idx_q] <= 1'b1;
							cnt_q <= cnt_q + 1'b1;
						end
					end
				end else if (match_q) begin
					// advance the free end past the released region
					if (fe_q == PTR_BITS'(CW'(rel_q))) begin
						fe_q <= next_found_q ? PTR_BITS'(CW'(next_q)) : total_q;
					end
					valid_q[match_idx_q] <= 1'b0;
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// Payload, scan accumulators and result registers
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= s_axis_tuser;
			size_q <= s_axis_tdata[24:0];
			rel_q <= in_ofs;
			idx_q <= '0;
			lowest_q <= '1;
			next_q <= '0;
			next_found_q <= 1'b0;
			hit_ap_q <= 1'b0;
			hit_zero_q <= 1'b0;
			match_q <= 1'b0;
			free_found_q <= 1'b0;
			match_idx_q <= '0;
			free_idx_q <= '0;
		end
		if (rd_en) idx_q <= idx_q + 1'b1;
		idx_s1 <= idx_q;
		if (vld_s1) begin
			if (!valid_q[idx_s1]) begin
				if (!free_found_q) begin
					free_found_q <= 1'b1;
					free_idx_q <= idx_s1;
				end
			end else begin
				if (rd_data < lowest_q) lowest_q <= rd_data;
				if (rd_data == start_ap) hit_ap_q <= 1'b1;
				if (rd_data == '0) hit_zero_q <= 1'b1;
				if (rd_data == rel_q) begin
					match_q <= 1'b1;
					match_idx_q <= idx_s1;
				end
				if (rd_data > rel_q && (!next_found_q || rd_data < next_q)) begin
					next_q <= rd_data;
					next_found_q <= 1'b1;
				end
			end
		end
		if (decide_go) begin
			if (req_q == REQ_ALLOC) begin
				out_cnt_q <= (size_q != '0 && !full && fit && !dup) ? cnt_q + 1'b1 : cnt_q;
				out_ofs_q <= (size_q != '0 && !full && fit) ? 24'(CW'(grant_start)) : 24'd0;
				if (size_q == '0) begin
					out_status_q <= ST_NO_ROOM;
				end else if (full) begin
					out_status_q <= ST_FULL;
				end else if (fit) begin
					out_status_q <= ST_GRANTED;
				end else if (empty || size_q > total_q) begin
					out_status_q <= ST_TOO_BIG;
				end else begin
					out_status_q <= ST_NO_ROOM;
				end
			end else begin
				out_ofs_q <= '0;
				out_status_q <= match_q ? ST_RELEASED : ST_UNKNOWN;
				out_cnt_q <= match_q ? cnt_q - 1'b1 : cnt_q;
			end
		end
	end

endmodule

// ===== hw/rtl/rbia_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module rbia_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
